[hw/rtl/gwn_pkg.sv]
`default_nettype none

package gwn_pkg;

    localparam int MAX_SIDE_DEF = 16;
    localparam int GRID_LAST_W  = 4;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic {
        MOVE_X = 1'b0,
        MOVE_Y = 1'b1
    } move_t;

    typedef struct packed {
        move_t move;
        logic  last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

`default_nettype wire

[hw/rtl/gwn_front.sv]
`default_nettype none

module gwn_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          symbol,
    input  wire logic          last,
    output gwn_pkg::head_t     head,
    input  wire logic          pop
);

    localparam int PW = $clog2(gwn_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(gwn_pkg::QUEUE_DEPTH + 1);

    gwn_pkg::item_t  queue_reg [gwn_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    gwn_pkg::item_t  item_in;
    logic            push;
    logic            do_pop;

    // classify the incoming symbol
    always_comb
    begin
        item_in.move = symbol ? gwn_pkg::MOVE_Y : gwn_pkg::MOVE_X;
        item_in.last = last;
    end

    assign in_stall = (count_reg == CW'(gwn_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(gwn_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(gwn_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[hw/rtl/gwn_back.sv]
`default_nettype none

module gwn_back #(
    parameter int MaxSide = gwn_pkg::MAX_SIDE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gwn_pkg::head_t                head,
    output logic                               pop,
    input  wire logic                          cfg_write,
    input  wire logic [gwn_pkg::GRID_LAST_W-1:0] cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               corner_reached,
    output logic                               verdict_valid
);

    localparam int NW = $clog2(MaxSide);
    localparam int CW = (NW > gwn_pkg::GRID_LAST_W) ? NW : gwn_pkg::GRID_LAST_W;

    logic [MaxSide-1:0][MaxSide-1:0] grid_reg, grid_next, grid_step;
    logic [MaxSide-1:0][MaxSide-1:0] grid_start;
    logic [NW-1:0]                   n_reg, n_next;
    logic [MaxSide-1:0]              in_range;
    logic                            out_valid_reg, out_valid_next;
    logic                            corner_reg, corner_next;
    logic                            verdict_reg, verdict_next;
    logic [CW-1:0]                   cfg_ext;

    // only cell (0,0) active
    always_comb
    begin
        grid_start       = '0;
        grid_start[0][0] = 1'b1;
    end

    // clamp grid_last (the last row and column index) to 1 .. MaxSide-1
    always_comb
    begin
        cfg_ext = CW'(cfg_data);
        if (cfg_ext == '0)
        begin
            n_next = NW'(1);
        end
        else if (cfg_ext > CW'(MaxSide - 1))
        begin
            n_next = NW'(MaxSide - 1);
        end
        else
        begin
            n_next = cfg_ext[NW-1:0];
        end
    end

    genvar r, c;
    generate
        for (r = 0; r < MaxSide; r++)
        begin : g_range
            assign in_range[r] = (NW'(r) <= n_reg);
        end
        for (r = 0; r < MaxSide; r++)
        begin : g_row
            for (c = 0; c < MaxSide; c++)
            begin : g_col
                logic lo_x, hi_x, lo_y, hi_y;
                if (c > 0)
                begin : g_lx
                    assign lo_x = grid_reg[r][c-1];
                end
                else
                begin : g_lx0
                    assign lo_x = 1'b0;
                end
                if (c < MaxSide - 1)
                begin : g_hx
                    assign hi_x = grid_reg[r][c+1];
                end
                else
                begin : g_hx0
                    assign hi_x = 1'b0;
                end
                if (r > 0)
                begin : g_ly
                    assign lo_y = grid_reg[r-1][c];
                end
                else
                begin : g_ly0
                    assign lo_y = 1'b0;
                end
                if (r < MaxSide - 1)
                begin : g_hy
                    assign hi_y = grid_reg[r+1][c];
                end
                else
                begin : g_hy0
                    assign hi_y = 1'b0;
                end
                assign grid_step[r][c] = in_range[r] && in_range[c] &&
                    ((head.item.move == gwn_pkg::MOVE_X) ? (lo_x | hi_x) : (lo_y | hi_y));
            end
        end
    endgenerate

    assign pop = head.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        grid_next      = grid_reg;
        out_valid_next = out_valid_reg && out_stall;
        corner_next    = corner_reg;
        verdict_next   = verdict_reg;
        if (pop)
        begin
            grid_next      = head.item.last ? grid_start : grid_step;
            out_valid_next = 1'b1;
            corner_next    = grid_step[n_reg][n_reg];
            verdict_next   = head.item.last;
        end
        if (cfg_write)
        begin
            grid_next = grid_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg      <= grid_start;
            n_reg         <= NW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            grid_reg      <= grid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                n_reg <= n_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg  <= corner_next;
        verdict_reg <= verdict_next;
    end

    assign out_valid      = out_valid_reg;
    assign corner_reached = corner_reg;
    assign verdict_valid  = verdict_reg;

endmodule

`default_nettype wire

[hw/rtl/grid_walk_nfa_acceptor.sv]
// channel   signals                               width  transfer when
// in        in_valid in_stall symbol last         1+1    in_valid && !in_stall
// out       out_valid out_stall corner_reached    1+1    out_valid && !out_stall
//           verdict_valid
// cfg       cfg_valid cfg_ready cfg_data          4      cfg_valid && cfg_ready
//
// one symbol per cycle while in_stall is low; all cells of the grid update at once in the back end
// a symbol passes through the two-entry queue and then into the result register
// reset leaves only cell (0,0) active and grid_last at 1; a cfg transfer restarts the walk
// out_stall holds the result register; the queue absorbs the input side, in_stall when full
`default_nettype none

module grid_walk_nfa_acceptor #(
    parameter int MaxSide = gwn_pkg::MAX_SIDE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            symbol,
    input  wire logic                            last,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 corner_reached,
    output logic                                 verdict_valid,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gwn_pkg::GRID_LAST_W-1:0] cfg_data
);

    gwn_pkg::head_t head;
    logic           pop;
    logic           cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    gwn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .symbol   (symbol),
        .last     (last),
        .head     (head),
        .pop      (pop)
    );

    gwn_back #(
        .MaxSide (MaxSide)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .corner_reached (corner_reached),
        .verdict_valid  (verdict_valid)
    );

endmodule

`default_nettype wire

[sim/grid_walk_corner_check.sv]
`timescale 1ns / 100ps

module grid_walk_corner_check (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic                            symbol,
    input  wire logic                            last,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic                            corner_reached,
    input  wire logic                            verdict_valid,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [gwn_pkg::GRID_LAST_W-1:0] cfg_data,
    output int                                   fail_count,
    output int                                   expected_count
);

    localparam int Side = gwn_pkg::MAX_SIDE_DEF;

    typedef logic [Side-1:0] row_t;

    typedef struct {
        logic corner;
        logic verdict;
    } verdict_t;

    row_t                            cells [Side];
    logic [gwn_pkg::GRID_LAST_W-1:0] grid_last_q;
    verdict_t                        corner_expect_q [$];

    function automatic int grid_n();
        int n;
        n = (grid_last_q == '0) ? 1 : int'(grid_last_q);
        if (n > Side - 1)
        begin
            n = Side - 1;
        end
        return n;
    endfunction

    function automatic void restart_walk();
        for (int r = 0; r < Side; r++)
        begin
            cells[r] = '0;
        end
        cells[0] = row_t'(1);
    endfunction

    // all cells move at once; moves off the grid are dropped by the mask and the row bounds
    function automatic logic advance_walk(input gwn_pkg::move_t mv);
        row_t nxt [Side];
        row_t mask;
        int   n;
        n = grid_n();
        mask = row_t'((1 << (n + 1)) - 1);
        for (int r = 0; r < Side; r++)
        begin
            nxt[r] = '0;
            if (r <= n)
            begin
                if (mv == gwn_pkg::MOVE_X)
                begin
                    nxt[r] = ((cells[r] << 1) | (cells[r] >> 1)) & mask;
                end
                else
                begin
                    if (r > 0)
                    begin
                        nxt[r] = nxt[r] | cells[r - 1];
                    end
                    if (r < n)
                    begin
                        nxt[r] = nxt[r] | cells[r + 1];
                    end
                    nxt[r] = nxt[r] & mask;
                end
            end
        end
        for (int r = 0; r < Side; r++)
        begin
            cells[r] = nxt[r];
        end
        return cells[n][n];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            grid_last_q = gwn_pkg::GRID_LAST_W'(1);
            restart_walk();
            corner_expect_q.delete();
            fail_count = 0;
            expected_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (corner_expect_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: corner_reached %0b verdict_valid %0b",
                           corner_reached, verdict_valid);
                    fail_count++;
                end
                else
                begin
                    want = corner_expect_q.pop_front();
                    if (corner_reached !== want.corner)
                    begin
                        $error("corner_reached: expected %0b, actual %0b",
                               want.corner, corner_reached);
                        fail_count++;
                    end
                    if (verdict_valid !== want.verdict)
                    begin
                        $error("verdict_valid: expected %0b, actual %0b",
                               want.verdict, verdict_valid);
                        fail_count++;
                    end
                end
            end
            // a register write restarts the walk
            if (cfg_valid && cfg_ready)
            begin
                grid_last_q = cfg_data;
                restart_walk();
            end
            if (in_valid && !in_stall)
            begin
                want.corner = advance_walk(gwn_pkg::move_t'(symbol));
                want.verdict = last;
                if (last)
                begin
                    restart_walk();
                end
                corner_expect_q.push_back(want);
            end
            expected_count = corner_expect_q.size();
        end
    end

endmodule

[sim/grid_walk_nfa_acceptor_tb.sv]
`timescale 1ns / 100ps

module grid_walk_nfa_acceptor_tb;

    localparam int PhaseCount = 9;
    localparam int WalkItems  = 140;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            symbol;
    logic                            last;
    logic                            out_valid;
    logic                            out_stall;
    logic                            corner_reached;
    logic                            verdict_valid;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [gwn_pkg::GRID_LAST_W-1:0] cfg_data;
    int                              fail_count;
    int                              expected_count;

    int                              burst_left;
    int                              phase_sent;

    grid_walk_nfa_acceptor i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .symbol         (symbol),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .corner_reached (corner_reached),
        .verdict_valid  (verdict_valid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    grid_walk_corner_check u_corner_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .symbol         (symbol),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .corner_reached (corner_reached),
        .verdict_valid  (verdict_valid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .expected_count (expected_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stall rate that changes now and then, plus long hold-offs
    initial
    begin
        int cyc;
        int hold_left;
        int stall_pct;
        out_stall = 1'b0;
        cyc = 0;
        hold_left = 0;
        stall_pct = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 300 || cyc == 4000)
            begin
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (cyc % 97 == 0)
                begin
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_item(input gwn_pkg::move_t mv, input logic lst);
        int gap;
        symbol   <= mv;
        last     <= lst;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        phase_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // aimed walks take enough x and y moves of the right parity to reach the far corner
    task automatic send_walk(input int n);
        int             kind;
        int             rx;
        int             ry;
        int             len;
        gwn_pkg::move_t mv;
        kind = $urandom_range(9);
        if (kind < 7)
        begin
            rx = n + 2 * $urandom_range(0, 2);
            ry = n + 2 * $urandom_range(0, 2);
            len = rx + ry;
            for (int k = 0; k < len; k++)
            begin
                if (rx > 0 && (ry == 0 || $urandom_range(1) == 1))
                begin
                    mv = gwn_pkg::MOVE_X;
                    rx--;
                end
                else
                begin
                    mv = gwn_pkg::MOVE_Y;
                    ry--;
                end
                if (k == len - 1 && $urandom_range(6) == 0)
                begin
                    mv = gwn_pkg::move_t'($urandom_range(1));
                end
                send_item(mv, k == len - 1);
            end
        end
        else if (kind < 9)
        begin
            len = $urandom_range(1, 2 * n + 6);
            for (int k = 0; k < len; k++)
            begin
                send_item(gwn_pkg::move_t'($urandom_range(1)), k == len - 1);
            end
        end
        else
        begin
            send_item(gwn_pkg::move_t'($urandom_range(1)), logic'($urandom_range(1)));
        end
    endtask

    task automatic write_grid_last(input logic [gwn_pkg::GRID_LAST_W-1:0] value);
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_count != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [gwn_pkg::GRID_LAST_W-1:0] grid_plan [PhaseCount];
        int                              n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        symbol     = 1'b0;
        last       = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        burst_left = 5;
        phase_sent = 0;
        grid_plan  = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd15, 4'd1, 4'd0, 4'd0};
        grid_plan[7] = gwn_pkg::GRID_LAST_W'($urandom_range(2, 14));
        grid_plan[8] = gwn_pkg::GRID_LAST_W'($urandom_range(0, 15));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walks on the reset grid
        send_item(gwn_pkg::MOVE_X, 1'b0);
        send_item(gwn_pkg::MOVE_Y, 1'b1);
        send_item(gwn_pkg::MOVE_Y, 1'b1);
        send_item(gwn_pkg::MOVE_X, 1'b0);
        send_item(gwn_pkg::MOVE_X, 1'b0);
        send_item(gwn_pkg::MOVE_Y, 1'b0);
        send_item(gwn_pkg::MOVE_Y, 1'b1);
        send_item(gwn_pkg::MOVE_Y, 1'b0);
        send_item(gwn_pkg::MOVE_X, 1'b0);
        send_item(gwn_pkg::MOVE_Y, 1'b0);
        send_item(gwn_pkg::MOVE_X, 1'b1);
        send_item(gwn_pkg::MOVE_X, 1'b1);

        for (int p = 0; p < PhaseCount; p++)
        begin
            if (p > 0)
            begin
                write_grid_last(grid_plan[p]);
            end
            n = (grid_plan[p] == '0) ? 1 : int'(grid_plan[p]);
            if (p == 1)
            begin
                // zero size behaves as a 2x2 grid
                send_item(gwn_pkg::MOVE_X, 1'b0);
                send_item(gwn_pkg::MOVE_Y, 1'b1);
            end
            if (p == 2)
            begin
                send_item(gwn_pkg::MOVE_Y, 1'b1);
            end
            phase_sent = 0;
            while (phase_sent < WalkItems)
            begin
                send_walk(n);
            end
            // walk left open so the next register write has to restart it
            send_item(gwn_pkg::MOVE_X, 1'b0);
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_count != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
